// ===== src/trr_pkg.sv =====
// Shared constants, codes and types of the token round-robin scheduler.
`timescale 1ns / 1ps

package trr_pkg;

    localparam int MAX_QUEUE    = 32;
    localparam int QA_W         = $clog2(MAX_QUEUE);
    localparam int QC_W         = $clog2(MAX_QUEUE + 1);
    localparam int TIME_BITS    = 48;
    localparam int ST_W         = 8;
    localparam int NUM_STATIONS = 1 << ST_W;
    localparam int RUN_W        = 16;
    localparam int SM_W         = TIME_BITS + RUN_W;
    localparam int LIMIT_W      = 34;
    localparam int CMP_W        = (TIME_BITS > LIMIT_W) ? TIME_BITS : LIMIT_W;
    localparam logic [RUN_W-1:0] SILENT_LIMIT = RUN_W'(2);
    localparam int ADDR_W       = 6;
    localparam int DATA_W       = 64;

    typedef enum logic [1:0] {
        OP_DECLARE = 2'd0,
        OP_OBSERVE = 2'd1,
        OP_GRANT   = 2'd2,
        OP_SCAN    = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        K_REJECTED     = 4'd0,
        K_REFRESHED    = 4'd1,
        K_ENQUEUED     = 4'd2,
        K_QUEUE_FULL   = 4'd3,
        K_OBSERVED     = 4'd4,
        K_NO_GRANT     = 4'd5,
        K_GRANT        = 4'd6,
        K_EVICTED      = 4'd7,
        K_NONE_EVICTED = 4'd8
    } kind_t;

    typedef enum logic [2:0] {
        REG_KNOWN_0      = 3'd0,
        REG_KNOWN_1      = 3'd1,
        REG_KNOWN_2      = 3'd2,
        REG_KNOWN_3      = 3'd3,
        REG_GRANT_LENGTH = 3'd4,
        REG_GUARD_GAP    = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic [3:0][63:0] known;
        logic [31:0]      grant_length;
        logic [31:0]      guard_gap;
    } cfg_t;

    typedef struct packed {
        kind_t                kind;
        logic [ST_W-1:0]      station;
        logic [31:0]          number;
        logic [TIME_BITS-1:0] quiet;
        logic [RUN_W-1:0]     quiet_grants;
        logic [QC_W-1:0]      qlen;
        logic [QA_W-1:0]      cursor;
        logic                 last;
    } item_t;

    typedef struct packed {
        logic  load;
        logic  mark;
        logic  q_rd;
        logic  q_rd_cur;
        logic  found_chk;
        logic  idx_inc;
        logic  enq;
        logic  st_rd;
        logic  grant_upd;
        logic  calc;
        logic  evict;
        logic  keep;
        logic  emit;
        logic  pend_load;
        logic  pend_flush;
        kind_t kind;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic known;
        logic count_zero;
        logic idx_end;
        logic found;
        logic full;
        logic evict_ok;
        logic pend_valid;
    } stat_t;

endpackage

// ===== src/trr_regs.sv =====
// Configuration register file behind the APB-style port.
`timescale 1ns / 1ps

module trr_regs (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [trr_pkg::ADDR_W-1:0] paddr,
    input  logic [trr_pkg::DATA_W-1:0] pwdata,
    output logic [trr_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output trr_pkg::cfg_t              cfg
);

    trr_pkg::cfg_t     cfg_reg;
    trr_pkg::reg_idx_t idx;

    assign idx    = trr_pkg::reg_idx_t'(paddr[5:3]);
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.known        <= '0;
            cfg_reg.grant_length <= 32'd1;
            cfg_reg.guard_gap    <= 32'd0;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (idx)
                trr_pkg::REG_KNOWN_0:      cfg_reg.known[0] <= pwdata;
                trr_pkg::REG_KNOWN_1:      cfg_reg.known[1] <= pwdata;
                trr_pkg::REG_KNOWN_2:      cfg_reg.known[2] <= pwdata;
                trr_pkg::REG_KNOWN_3:      cfg_reg.known[3] <= pwdata;
                trr_pkg::REG_GRANT_LENGTH: cfg_reg.grant_length <= pwdata[31:0];
                trr_pkg::REG_GUARD_GAP:    cfg_reg.guard_gap <= pwdata[31:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            trr_pkg::REG_KNOWN_0:      prdata = cfg_reg.known[0];
            trr_pkg::REG_KNOWN_1:      prdata = cfg_reg.known[1];
            trr_pkg::REG_KNOWN_2:      prdata = cfg_reg.known[2];
            trr_pkg::REG_KNOWN_3:      prdata = cfg_reg.known[3];
            trr_pkg::REG_GRANT_LENGTH: prdata = {32'd0, cfg_reg.grant_length};
            trr_pkg::REG_GUARD_GAP:    prdata = {32'd0, cfg_reg.guard_gap};
            default:                   prdata = '0;
        endcase
    end

endmodule

// ===== src/trr_ctrl.sv =====
// Sequencer that steps each operation through the datapath.
`timescale 1ns / 1ps

module trr_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  trr_pkg::stat_t stat,
    output trr_pkg::cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_DISPATCH, S_D_RD, S_D_CMP, S_D_DONE, S_EMIT,
        S_G_RD, S_G_MEM, S_G_UPD,
        S_S_RD, S_S_MEM, S_S_CALC, S_S_DEC, S_S_EV, S_S_END
    } state_t;

    state_t         state_reg, state_next;
    trr_pkg::kind_t kind_reg, kind_next;

    assign busy = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            kind_reg  <= trr_pkg::K_REJECTED;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        cmd        = '0;
        cmd.kind   = kind_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                unique case (stat.op)
                    trr_pkg::OP_DECLARE:
                    begin
                        if (stat.known)
                        begin
                            cmd.mark   = 1'b1;
                            state_next = S_D_RD;
                        end
                        else
                        begin
                            kind_next  = trr_pkg::K_REJECTED;
                            state_next = S_EMIT;
                        end
                    end
                    trr_pkg::OP_OBSERVE:
                    begin
                        cmd.mark   = stat.known;
                        kind_next  = stat.known ? trr_pkg::K_OBSERVED : trr_pkg::K_REJECTED;
                        state_next = S_EMIT;
                    end
                    trr_pkg::OP_GRANT:
                    begin
                        if (stat.count_zero)
                        begin
                            kind_next  = trr_pkg::K_NO_GRANT;
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            state_next = S_G_RD;
                        end
                    end
                    default: state_next = S_S_RD;
                endcase
            end
            S_D_RD:
            begin
                if (stat.idx_end)
                begin
                    state_next = S_D_DONE;
                end
                else
                begin
                    cmd.q_rd   = 1'b1;
                    state_next = S_D_CMP;
                end
            end
            S_D_CMP:
            begin
                cmd.found_chk = 1'b1;
                cmd.idx_inc   = 1'b1;
                state_next    = S_D_RD;
            end
            S_D_DONE:
            begin
                if (stat.found)
                begin
                    kind_next = trr_pkg::K_REFRESHED;
                end
                else if (stat.full)
                begin
                    kind_next = trr_pkg::K_QUEUE_FULL;
                end
                else
                begin
                    cmd.enq   = 1'b1;
                    kind_next = trr_pkg::K_ENQUEUED;
                end
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                cmd.emit   = 1'b1;
                state_next = S_IDLE;
            end
            S_G_RD:
            begin
                cmd.q_rd_cur = 1'b1;
                state_next   = S_G_MEM;
            end
            S_G_MEM:
            begin
                cmd.st_rd  = 1'b1;
                state_next = S_G_UPD;
            end
            S_G_UPD:
            begin
                cmd.grant_upd = 1'b1;
                kind_next     = trr_pkg::K_GRANT;
                state_next    = S_EMIT;
            end
            S_S_RD:
            begin
                if (stat.idx_end)
                begin
                    state_next = S_S_END;
                end
                else
                begin
                    cmd.q_rd   = 1'b1;
                    state_next = S_S_MEM;
                end
            end
            S_S_MEM:
            begin
                cmd.st_rd  = 1'b1;
                state_next = S_S_CALC;
            end
            S_S_CALC:
            begin
                cmd.calc   = 1'b1;
                state_next = S_S_DEC;
            end
            S_S_DEC:
            begin
                cmd.idx_inc = 1'b1;
                if (stat.evict_ok)
                begin
                    cmd.evict  = 1'b1;
                    state_next = S_S_EV;
                end
                else
                begin
                    cmd.keep   = 1'b1;
                    state_next = S_S_RD;
                end
            end
            S_S_EV:
            begin
                cmd.pend_load = 1'b1;
                cmd.kind      = trr_pkg::K_EVICTED;
                state_next    = S_S_RD;
            end
            S_S_END:
            begin
                if (stat.pend_valid)
                begin
                    cmd.pend_flush = 1'b1;
                end
                else
                begin
                    cmd.emit = 1'b1;
                    cmd.kind = trr_pkg::K_NONE_EVICTED;
                end
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

// ===== src/trr_dp.sv =====
// Queue memory, station table, counters and result registers.
`timescale 1ns / 1ps

module trr_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [1:0]                    operation,
    input  logic [trr_pkg::ST_W-1:0]      station,
    input  logic [trr_pkg::TIME_BITS-1:0] time_now,
    input  trr_pkg::cfg_t                 cfg,
    input  trr_pkg::cmd_t                 cmd,
    output trr_pkg::stat_t                stat,
    output trr_pkg::item_t                out_item,
    output logic                          out_valid
);

    localparam int QA_W  = trr_pkg::QA_W;
    localparam int QC_W  = trr_pkg::QC_W;
    localparam int TB    = trr_pkg::TIME_BITS;
    localparam int SW    = trr_pkg::ST_W;
    localparam int RW    = trr_pkg::RUN_W;
    localparam int SM_W  = trr_pkg::SM_W;
    localparam int CMP_W = trr_pkg::CMP_W;

    logic [SW-1:0]   q_mem [trr_pkg::MAX_QUEUE];
    logic [SW-1:0]   q_dout_reg;
    logic [SM_W-1:0] sm_mem [trr_pkg::NUM_STATIONS];
    logic [SM_W-1:0] sm_dout_reg;
    logic [trr_pkg::NUM_STATIONS-1:0] sv_reg;
    logic            sv_rd_reg;

    trr_pkg::op_t    op_reg;
    logic [SW-1:0]   st_reg;
    logic [TB-1:0]   now_reg;
    logic [QC_W-1:0] count_reg, bound_reg, idx_reg, wr_reg;
    logic [QA_W-1:0] cursor_reg;
    logic [31:0]     grant_ctr_reg, num_reg;
    logic            found_reg;
    logic [SW-1:0]   g_reg;
    logic [TB-1:0]   quiet_reg;
    logic [RW-1:0]   run_reg;
    trr_pkg::item_t  pend_reg, out_reg, item, out_word;
    logic            pend_valid_reg, out_valid_reg;

    logic [TB-1:0]   ls;
    logic [RW-1:0]   run;
    logic            fresh;
    logic [RW-1:0]   run_new;
    logic [trr_pkg::LIMIT_W-1:0] limit;
    logic [QC_W-1:0] newcnt;
    logic [QA_W-1:0] cursor_inc;

    logic            q_we;
    logic [QA_W-1:0] q_waddr;
    logic [SW-1:0]   q_wdata;
    logic            sm_we;
    logic [SW-1:0]   sm_waddr;
    logic [SM_W-1:0] sm_wdata;

    // An entry never written reads as zero.
    assign ls      = sv_rd_reg ? sm_dout_reg[SM_W-1:RW] : '0;
    assign run     = sv_rd_reg ? sm_dout_reg[RW-1:0] : '0;
    assign fresh   = (ls == '0) || (now_reg <= ls);
    assign run_new = fresh ? '0 : ((run == '1) ? run : run + RW'(1));
    assign limit   = (trr_pkg::LIMIT_W'(cfg.grant_length)
                      + trr_pkg::LIMIT_W'(cfg.guard_gap)) << 1;
    assign newcnt  = count_reg - QC_W'(1);
    assign cursor_inc = ((QC_W'(cursor_reg) + QC_W'(1)) == count_reg) ? '0
                        : cursor_reg + QA_W'(1);

    assign q_we    = cmd.enq || cmd.keep;
    assign q_waddr = cmd.enq ? count_reg[QA_W-1:0] : wr_reg[QA_W-1:0];
    assign q_wdata = cmd.enq ? st_reg : g_reg;

    assign sm_we    = cmd.mark || cmd.grant_upd;
    assign sm_waddr = cmd.mark ? st_reg : g_reg;
    assign sm_wdata = cmd.mark ? {now_reg, RW'(0)} : {ls, run_new};

    always_ff @(posedge clk)
    begin
        if (q_we)
        begin
            q_mem[q_waddr] <= q_wdata;
        end
        if (cmd.q_rd)
        begin
            q_dout_reg <= q_mem[idx_reg[QA_W-1:0]];
        end
        else if (cmd.q_rd_cur)
        begin
            q_dout_reg <= q_mem[cursor_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (sm_we)
        begin
            sm_mem[sm_waddr] <= sm_wdata;
        end
        if (cmd.st_rd)
        begin
            sm_dout_reg <= sm_mem[q_dout_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sv_reg    <= '0;
            sv_rd_reg <= 1'b0;
        end
        else
        begin
            if (sm_we)
            begin
                sv_reg[sm_waddr] <= 1'b1;
            end
            if (cmd.st_rd)
            begin
                sv_rd_reg <= sv_reg[q_dout_reg];
            end
        end
    end

    // Input word and per-operation scratch.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= trr_pkg::op_t'(operation);
            st_reg  <= station;
            now_reg <= time_now;
        end
        if (cmd.st_rd)
        begin
            g_reg <= q_dout_reg;
        end
        if (cmd.calc)
        begin
            quiet_reg <= (ls != '0 && now_reg > ls) ? now_reg - ls : '0;
            run_reg   <= run;
        end
        if (cmd.grant_upd)
        begin
            num_reg <= grant_ctr_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            cursor_reg    <= '0;
            grant_ctr_reg <= '0;
            idx_reg       <= '0;
            wr_reg        <= '0;
            bound_reg     <= '0;
            found_reg     <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                idx_reg   <= '0;
                wr_reg    <= '0;
                bound_reg <= count_reg;
                found_reg <= 1'b0;
            end
            if (cmd.idx_inc)
            begin
                idx_reg <= idx_reg + QC_W'(1);
            end
            if (cmd.found_chk && q_dout_reg == st_reg)
            begin
                found_reg <= 1'b1;
            end
            if (cmd.enq)
            begin
                count_reg <= count_reg + QC_W'(1);
            end
            if (cmd.keep)
            begin
                wr_reg <= wr_reg + QC_W'(1);
            end
            if (cmd.grant_upd)
            begin
                grant_ctr_reg <= grant_ctr_reg + 32'd1;
                cursor_reg    <= cursor_inc;
            end
            if (cmd.evict)
            begin
                count_reg <= newcnt;
                if (newcnt == '0)
                begin
                    cursor_reg <= '0;
                end
                else if (wr_reg < QC_W'(cursor_reg))
                begin
                    cursor_reg <= cursor_reg - QA_W'(1);
                end
                else if (wr_reg == QC_W'(cursor_reg) && QC_W'(cursor_reg) == newcnt)
                begin
                    cursor_reg <= '0;
                end
            end
        end
    end

    always_comb
    begin
        item              = '0;
        item.kind         = cmd.kind;
        item.qlen         = count_reg;
        item.cursor       = cursor_reg;
        case (cmd.kind) inside
            trr_pkg::K_NO_GRANT, trr_pkg::K_NONE_EVICTED: item.station = '0;
            trr_pkg::K_GRANT:
            begin
                item.station = g_reg;
                item.number  = num_reg;
            end
            trr_pkg::K_EVICTED:
            begin
                item.station      = g_reg;
                item.quiet        = quiet_reg;
                item.quiet_grants = run_reg;
            end
            default: item.station = st_reg;
        endcase
    end

    // Evictions wait one step in the pending word so the last one can be marked.
    always_comb
    begin
        out_word      = cmd.emit ? item : pend_reg;
        out_word.last = cmd.emit || cmd.pend_flush;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit || cmd.pend_load || cmd.pend_flush)
        begin
            out_reg <= out_word;
        end
        if (cmd.pend_load)
        begin
            pend_reg <= item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= cmd.emit || cmd.pend_flush || (cmd.pend_load && pend_valid_reg);
            if (cmd.pend_load)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (cmd.pend_flush)
            begin
                pend_valid_reg <= 1'b0;
            end
        end
    end

    assign out_item  = out_reg;
    assign out_valid = out_valid_reg;

    assign stat.op         = op_reg;
    assign stat.known      = cfg.known[st_reg[7:6]][st_reg[5:0]];
    assign stat.count_zero = (count_reg == '0);
    assign stat.idx_end    = (idx_reg >= bound_reg);
    assign stat.found      = found_reg;
    assign stat.full       = (count_reg >= QC_W'(trr_pkg::MAX_QUEUE));
    assign stat.evict_ok   = (g_reg != st_reg)
                             && (CMP_W'(quiet_reg) >= CMP_W'(limit))
                             && (run_reg >= trr_pkg::SILENT_LIMIT);
    assign stat.pend_valid = pend_valid_reg;

endmodule

// ===== src/token_round_robin_with_eviction.sv =====
// Top level of the token round-robin scheduler with silent-station eviction.
// Observe and rejected words go from dispatch straight to the result; grant reads the queue
// and station table first, declare walks the queue, and scan walks it with an extra step per eviction.
// One word is worked at a time: busy stays high until the final result is registered, and
// the queue walk (one memory read per entry, plus the station table read in a scan) sets it.
// Results appear for one cycle each under result_valid; the receiver cannot stall them.
// Reset (rst_n, asynchronous, active low) empties the queue, zeroes the cursor and grant
// counter and marks every station table entry unwritten, so it reads as zero at once.
`timescale 1ns / 1ps

module token_round_robin_with_eviction (
    input  logic                          clk,
    input  logic                          rst_n,
    // Operation word.
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    operation,
    input  logic [trr_pkg::ST_W-1:0]      station,
    input  logic [trr_pkg::TIME_BITS-1:0] time_now,
    // Result word.
    output logic                          result_valid,
    output logic [3:0]                    result_kind,
    output logic [trr_pkg::ST_W-1:0]      out_station,
    output logic [31:0]                   grant_number,
    output logic [trr_pkg::TIME_BITS-1:0] quiet_time,
    output logic [trr_pkg::RUN_W-1:0]     quiet_grants,
    output logic [trr_pkg::QC_W-1:0]      queue_length,
    output logic [trr_pkg::QA_W-1:0]      cursor_position,
    output logic                          last_of_run,
    // Configuration port.
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [trr_pkg::ADDR_W-1:0]    paddr,
    input  logic [trr_pkg::DATA_W-1:0]    pwdata,
    output logic [trr_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);

    trr_pkg::cfg_t  cfg;
    trr_pkg::cmd_t  cmd;
    trr_pkg::stat_t stat;
    trr_pkg::item_t item;

    // Register file: known station masks and the window timing.
    trr_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // The sequencer accepts a word when idle and walks it through the datapath.
    trr_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    // The datapath compacts the queue in place during a scan, so a removal costs no
    // extra shifting pass; evictions are held one step to mark the final one.
    trr_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .operation (operation),
        .station   (station),
        .time_now  (time_now),
        .cfg       (cfg),
        .cmd       (cmd),
        .stat      (stat),
        .out_item  (item),
        .out_valid (result_valid)
    );

    assign result_kind     = item.kind;
    assign out_station     = item.station;
    assign grant_number    = item.number;
    assign quiet_time      = item.quiet;
    assign quiet_grants    = item.quiet_grants;
    assign queue_length    = item.qlen;
    assign cursor_position = item.cursor;
    assign last_of_run     = item.last;

endmodule

// ===== src/trr_checker.sv =====
// Port-level checks of the scheduler, bound to the top level.
`timescale 1ns / 1ps

module trr_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      start,
    input logic                      busy,
    input logic                      result_valid,
    input logic [3:0]                result_kind,
    input logic [trr_pkg::QC_W-1:0]  queue_length,
    input logic [trr_pkg::QA_W-1:0]  cursor_position,
    input logic                      last_of_run
);

    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after an accepted word");

    a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && last_of_run) |=> !result_valid)
        else $error("result directly after the final result of a word");

    a_mid_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !last_of_run) |-> busy)
        else $error("non-final result while idle");

    a_cursor_in_queue: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ((queue_length == '0 && cursor_position == '0)
                          || ({1'b0, cursor_position} < queue_length)))
        else $error("cursor outside the queue");

    a_no_grant_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_kind == trr_pkg::K_NO_GRANT) |-> (queue_length == '0))
        else $error("no grant reported with a non-empty queue");

endmodule

bind token_round_robin_with_eviction trr_checker u_trr_checker (.*);
